[design/llma_pkg.sv]
// Shared types and constants for the least-loaded machine assigner.
package llma_pkg;

    localparam int LOAD_W = 32;
    localparam int CFG_W  = 5;
    localparam int ID_W   = 16;
    localparam int TIME_W = 16;
    localparam int MACH_W = 4;

    typedef logic [LOAD_W-1:0] t_load;

    localparam t_load LOAD_MAX = '1;

    // Control strobes from the sequencer to the load memory.
    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

[design/least_loaded_machine_assigner.sv]
// Least-loaded machine assigner: greedy list scheduling over a load memory.
// A result beat is registered once its job beat has been accepted and the scan, a drain
// step and the write-back step are done (M = machines in use after clamping), later while the output is stalled.
// o_stall holds off a new job until the previous result is registered; the scan of the load memory
// reads one stored load per cycle through its single read port.
// Reset (synchronous, active low): all loads zero, empty batch, M = 1.
module least_loaded_machine_assigner #(
    parameter int MAX_MACHINES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config
    input  logic                        i_cfg_we,
    input  logic [llma_pkg::CFG_W-1:0]  i_cfg_wdata,
    // job beats
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [llma_pkg::ID_W-1:0]   i_job_id,
    input  logic [llma_pkg::TIME_W-1:0] i_job_time,
    input  logic                        i_new_batch,
    // result beats
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [llma_pkg::ID_W-1:0]   o_assigned_job,
    output logic [llma_pkg::MACH_W-1:0] o_chosen_machine,
    output llma_pkg::t_load             o_machine_total,
    output llma_pkg::t_load             o_batch_makespan,
    output logic                        o_load_saturated
);

    localparam int AW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    // counts up to MAX_MACHINES itself
    localparam int CW = $clog2(MAX_MACHINES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [llma_pkg::CFG_W-1:0]    r_cfg;
    logic [CW-1:0]                 r_jobs;      // jobs placed in order this batch
    logic [CW-1:0]                 r_m;         // machines in use, latched per job
    logic [CW-1:0]                 r_cnt;       // scan read address
    logic                          r_pend;      // read data arrives this cycle
    logic [AW-1:0]                 r_pidx;      // index of that data
    logic                          r_inorder;
    logic [AW-1:0]                 r_pick;      // in-order target
    logic [llma_pkg::ID_W-1:0]     r_id;
    logic [llma_pkg::TIME_W-1:0]   r_time;
    llma_pkg::t_load               r_min;
    logic [AW-1:0]                 r_argmin;
    llma_pkg::t_load               r_max;
    llma_pkg::t_load               r_pick_load;

    logic                          r_ovalid;
    logic [llma_pkg::ID_W-1:0]     r_o_id;
    logic [llma_pkg::MACH_W-1:0]   r_o_mach;
    llma_pkg::t_load               r_o_total;
    llma_pkg::t_load               r_o_span;
    logic                          r_o_sat;

    logic [CW-1:0]                 n_m;
    logic [CW-1:0]                 n_jobs_eff;
    logic                          w_accept;
    logic                          w_out_free;
    llma_pkg::t_mem_ctl            w_ctl;
    llma_pkg::t_load               w_rd_data;
    logic [AW-1:0]                 w_sel;
    llma_pkg::t_load               w_base;
    logic [llma_pkg::LOAD_W:0]     w_sum;
    llma_pkg::t_load               w_total;
    llma_pkg::t_load               w_span;
    logic [AW+llma_pkg::MACH_W-1:0] w_sel_ext;

    // effective machine count: 0 means 1, anything past the build limit is the limit
    always_comb begin
        if (r_cfg == '0) begin
            n_m = CW'(1);
        end else if (32'(r_cfg) > 32'(MAX_MACHINES)) begin
            n_m = CW'(MAX_MACHINES);
        end else begin
            n_m = CW'(r_cfg);
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_ovalid || !i_stall;
    assign n_jobs_eff = i_new_batch ? '0 : r_jobs;

    // final pick, saturating add and the new makespan
    assign w_sel  = r_inorder ? r_pick : r_argmin;
    assign w_base = r_inorder ? r_pick_load : r_min;
    assign w_sum  = {1'b0, w_base} + (llma_pkg::LOAD_W + 1)'(r_time);
    assign w_total = (w_sum >= {1'b0, llma_pkg::LOAD_MAX}) ? llma_pkg::LOAD_MAX
                                                            : w_sum[llma_pkg::LOAD_W-1:0];
    // loads only grow, so the new maximum is the old one or the updated entry
    assign w_span    = (w_total > r_max) ? w_total : r_max;
    assign w_sel_ext = {{llma_pkg::MACH_W{1'b0}}, w_sel};

    always_comb begin
        w_ctl.clear = w_accept && i_new_batch;
        w_ctl.rd_en = (r_state == S_SCAN);
        w_ctl.wr_en = (r_state == S_DONE) && w_out_free;
    end

    llma_load_mem #(
        .DEPTH (MAX_MACHINES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (r_cnt[AW-1:0]),
        .i_wr_addr (w_sel),
        .i_wr_data (w_total),
        .o_rd_data (w_rd_data)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= llma_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // sequencer: accept, scan loads (min, argmin, max), write back, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_jobs   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // result register: loads on the final step, holds while stalled
            if ((r_state == S_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end

            // consume the read beat issued in the previous cycle
            r_pend <= (r_state == S_SCAN);
            if (r_pend) begin
                if (r_pidx == '0) begin
                    r_min    <= w_rd_data;
                    r_argmin <= '0;
                    r_max    <= w_rd_data;
                end else begin
                    if (w_rd_data < r_min) begin
                        r_min    <= w_rd_data;
                        r_argmin <= r_pidx;
                    end
                    if (w_rd_data > r_max) begin
                        r_max <= w_rd_data;
                    end
                end
                if (r_pidx == r_pick) begin
                    r_pick_load <= w_rd_data;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_id      <= i_job_id;
                        r_time    <= i_job_time;
                        r_m       <= n_m;
                        r_jobs    <= n_jobs_eff;
                        r_inorder <= (n_jobs_eff < n_m);
                        r_pick    <= n_jobs_eff[AW-1:0];
                        r_cnt     <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pidx <= r_cnt[AW-1:0];
                    r_cnt  <= r_cnt + CW'(1);
                    if (r_cnt == r_m - CW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_id    <= r_id;
                        r_o_mach  <= w_sel_ext[llma_pkg::MACH_W-1:0];
                        r_o_total <= w_total;
                        r_o_span  <= w_span;
                        r_o_sat   <= (w_total == llma_pkg::LOAD_MAX);
                        if (r_inorder) begin
                            r_jobs <= r_jobs + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_assigned_job   = r_o_id;
    assign o_chosen_machine = r_o_mach;
    assign o_machine_total  = r_o_total;
    assign o_batch_makespan = r_o_span;
    assign o_load_saturated = r_o_sat;

endmodule

[design/llma_load_mem.sv]
// Machine load memory: registered read, per-entry valid bits, batch clear.
module llma_load_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  llma_pkg::t_mem_ctl  i_ctl,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic [AW-1:0]       i_wr_addr,
    input  llma_pkg::t_load     i_wr_data,
    output llma_pkg::t_load     o_rd_data
);

    llma_pkg::t_load r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    llma_pkg::t_load r_rd_data;
    logic            r_rd_vld;

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid bits: an entry never written since the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_vld <= '0;
            end else if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
